// ===== rtl/core/pcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int NUM_FEAT   = 9;
  localparam int NUM_CH     = 3;
  localparam int NUM_REGS   = 7;
  localparam int NUM_COEF   = NUM_FEAT * NUM_CH;
  localparam int COEF_BITS  = 16;
  localparam int FEAT_BITS  = 17;
  localparam int TERM_BITS  = 21;
  localparam int PART_BITS  = 22;
  localparam int SUM_BITS   = 24;
  localparam int REG_BITS   = 64;
  localparam int ADDR_BITS  = 6;
  localparam int IDX_BITS   = 3;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_COEF_0_3   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_COEF_4_7   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_COEF_8_11  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_COEF_12_15 = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_COEF_16_19 = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_COEF_20_23 = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_COEF_24_26 = 3'd6;

  localparam int LAST_REG_BITS = 48;

  // identity mapping after reset
  localparam logic [REG_BITS-1:0] COEF_RESET [NUM_REGS] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_0000_0000,
    64'h0000_1000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_1000,
    64'h0000_0000_0000_0000
  };

  typedef logic [PIXEL_BITS-1:0]       pixel_t;
  typedef logic [FEAT_BITS-1:0]        feat_t;
  typedef feat_t [NUM_FEAT-1:0]        feat_vec_t;
  typedef logic [COEF_BITS-1:0]        coef_t;
  typedef coef_t [NUM_FEAT-1:0]        coef_row_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  typedef struct packed {
    logic norm_en;
    logic feat_en;
    logic term_en;
    logic part_en;
    logic sum_en;
    logic out_en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/polynomial_color_correction.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in        sink       in_valid / in_ready   in_red, in_green, in_blue (8 bits each)
// out       source     out_valid / out_ready out_red, out_green, out_blue (8 bits each)
// apb       slave      psel/penable/pready   paddr[5:0], pwdata/prdata 64 bits, reg i at 8*i
//
// six pipeline stages: normalise, features, terms, partial sums, lane sums, scale and clamp
// one item per clock sustained while out_ready stays high; an item passes each stage register in turn
// each stage moves on when empty or when the stage after it moves, so bubbles are squeezed
// out and a stalled output keeps taking items until the pipeline is full
// rst (synchronous) empties the pipeline and loads the identity coefficients

module polynomial_color_correction (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_red,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_blue,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [pcc_pkg::REG_BITS-1:0]  pwdata,
  output logic [pcc_pkg::REG_BITS-1:0]       prdata,
  output logic                               pready
);

  logic [pcc_pkg::REG_BITS-1:0] coef_regs [pcc_pkg::NUM_REGS];
  logic [pcc_pkg::IDX_BITS-1:0] reg_idx;
  logic                         reg_hit;
  logic                         cfg_write;
  pcc_pkg::coef_row_t           coef_row [pcc_pkg::NUM_CH];
  pcc_pkg::feat_vec_t           feat;
  pcc_pkg::sum_t                lane_sum [pcc_pkg::NUM_CH];
  pcc_pkg::pipe_ctl_t           ctl;
  logic [6:1]                   vld;
  logic [6:1]                   vld_next;

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[pcc_pkg::ADDR_BITS-1:3];
  assign reg_hit   = (reg_idx < pcc_pkg::IDX_BITS'(pcc_pkg::NUM_REGS));
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_regs <= pcc_pkg::COEF_RESET;
    end else if (cfg_write) begin
      if (reg_idx == pcc_pkg::REG_COEF_24_26) begin
        coef_regs[reg_idx] <= {{(pcc_pkg::REG_BITS - pcc_pkg::LAST_REG_BITS){1'b0}},
                               pwdata[pcc_pkg::LAST_REG_BITS-1:0]};
      end else begin
        coef_regs[reg_idx] <= pwdata;
      end
    end
  end

  always_comb begin
    if (reg_hit) begin
      prdata = coef_regs[reg_idx];
    end else begin
      prdata = '0;
    end
  end

  // coefficient k sits in register k/4, 16-bit lane k%4
  for (genvar c = 0; c < pcc_pkg::NUM_CH; c++) begin : g_row
    for (genvar i = 0; i < pcc_pkg::NUM_FEAT; i++) begin : g_coef
      localparam int K = c * pcc_pkg::NUM_FEAT + i;
      assign coef_row[c][i] = coef_regs[K / 4][pcc_pkg::COEF_BITS * (K % 4) +:
                                                pcc_pkg::COEF_BITS];
    end
  end

  // stage enables: a stage loads when empty or when its successor moves on
  always_comb begin
    ctl.out_en  = !vld[6] || out_ready;
    ctl.sum_en  = !vld[5] || ctl.out_en;
    ctl.part_en = !vld[4] || ctl.sum_en;
    ctl.term_en = !vld[3] || ctl.part_en;
    ctl.feat_en = !vld[2] || ctl.term_en;
    ctl.norm_en = !vld[1] || ctl.feat_en;
    in_ready    = ctl.norm_en;
    vld_next[1] = ctl.norm_en ? in_valid : vld[1];
    vld_next[2] = ctl.feat_en ? vld[1]   : vld[2];
    vld_next[3] = ctl.term_en ? vld[2]   : vld[3];
    vld_next[4] = ctl.part_en ? vld[3]   : vld[4];
    vld_next[5] = ctl.sum_en  ? vld[4]   : vld[5];
    vld_next[6] = ctl.out_en  ? vld[5]   : vld[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign out_valid = vld[6];

  pcc_feat u_feat (
    .clk   (clk),
    .ctl   (ctl),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .feat  (feat)
  );

  for (genvar c = 0; c < pcc_pkg::NUM_CH; c++) begin : g_lane
    pcc_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef_row[c]),
      .feat (feat),
      .sum  (lane_sum[c])
    );
  end

  pcc_merge u_merge (
    .clk   (clk),
    .ctl   (ctl),
    .sum_r (lane_sum[0]),
    .sum_g (lane_sum[1]),
    .sum_b (lane_sum[2]),
    .red   (out_red),
    .green (out_green),
    .blue  (out_blue)
  );

  a_reset_empties: assert property (@(posedge clk) rst |=> (vld == '0) && !out_valid)
    else $error("pipeline not empty after reset");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although output is being taken");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[1])
    else $error("accepted item lost at first stage");

  a_sum_moves_out: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !vld[6] |=> out_valid)
    else $error("lane sums did not reach output register");

endmodule

`default_nettype wire

// ===== rtl/core/pcc_feat.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_feat (
  input  wire logic                clk,
  input  wire pcc_pkg::pipe_ctl_t  ctl,
  input  wire pcc_pkg::pixel_t     red,
  input  wire pcc_pkg::pixel_t     green,
  input  wire pcc_pkg::pixel_t     blue,
  output pcc_pkg::feat_vec_t       feat
);

  pcc_pkg::feat_t norm_r, norm_g, norm_b;
  pcc_pkg::feat_t norm_r_next, norm_g_next, norm_b_next;
  logic [2*pcc_pkg::FEAT_BITS-1:0] prod [6];
  pcc_pkg::feat_vec_t feat_next;

  // x*65536/255 rounded: 257*x plus one when x is in the upper half
  function automatic pcc_pkg::feat_t normalize(input pcc_pkg::pixel_t x);
    return {1'b0, x, x} + pcc_pkg::FEAT_BITS'(x[pcc_pkg::PIXEL_BITS-1]);
  endfunction

  always_comb begin
    norm_r_next = normalize(red);
    norm_g_next = normalize(green);
    norm_b_next = normalize(blue);
  end

  always_ff @(posedge clk) begin
    if (ctl.norm_en) begin
      norm_r <= norm_r_next;
      norm_g <= norm_g_next;
      norm_b <= norm_b_next;
    end
  end

  always_comb begin
    prod[0] = 34'(norm_r) * 34'(norm_g);
    prod[1] = 34'(norm_r) * 34'(norm_b);
    prod[2] = 34'(norm_g) * 34'(norm_b);
    prod[3] = 34'(norm_r) * 34'(norm_r);
    prod[4] = 34'(norm_g) * 34'(norm_g);
    prod[5] = 34'(norm_b) * 34'(norm_b);
    feat_next[0] = norm_r;
    feat_next[1] = norm_g;
    feat_next[2] = norm_b;
    for (int i = 0; i < 6; i++) begin
      feat_next[i+3] = pcc_pkg::FEAT_BITS'((prod[i] + 34'd32768) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.feat_en) begin
      feat <= feat_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_lane (
  input  wire logic                clk,
  input  wire pcc_pkg::pipe_ctl_t  ctl,
  input  wire pcc_pkg::coef_row_t  coef,
  input  wire pcc_pkg::feat_vec_t  feat,
  output pcc_pkg::sum_t            sum
);

  logic signed [33:0] prod [pcc_pkg::NUM_FEAT];
  logic signed [pcc_pkg::TERM_BITS-1:0] term [pcc_pkg::NUM_FEAT];
  logic signed [pcc_pkg::TERM_BITS-1:0] term_next [pcc_pkg::NUM_FEAT];
  logic signed [pcc_pkg::PART_BITS-1:0] part [3];
  logic signed [pcc_pkg::PART_BITS-1:0] part_next [3];
  pcc_pkg::sum_t sum_next;

  // Q4.12 times unsigned Q1.16 feature, rounded half up back to 16 fraction bits
  always_comb begin
    for (int i = 0; i < pcc_pkg::NUM_FEAT; i++) begin
      prod[i] = ($signed(coef[i]) * $signed({1'b0, feat[i]})) + 34'sd2048;
      term_next[i] = prod[i][32:12];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.term_en) begin
      term <= term_next;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      part_next[j] = pcc_pkg::PART_BITS'(term[3*j]) + pcc_pkg::PART_BITS'(term[3*j+1])
                   + pcc_pkg::PART_BITS'(term[3*j+2]);
    end
    sum_next = pcc_pkg::SUM_BITS'(part[0]) + pcc_pkg::SUM_BITS'(part[1])
             + pcc_pkg::SUM_BITS'(part[2]);
  end

  always_ff @(posedge clk) begin
    if (ctl.part_en) begin
      part <= part_next;
    end
    if (ctl.sum_en) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcc_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcc_merge (
  input  wire logic                clk,
  input  wire pcc_pkg::pipe_ctl_t  ctl,
  input  wire pcc_pkg::sum_t       sum_r,
  input  wire pcc_pkg::sum_t       sum_g,
  input  wire pcc_pkg::sum_t       sum_b,
  output pcc_pkg::pixel_t          red,
  output pcc_pkg::pixel_t          green,
  output pcc_pkg::pixel_t          blue
);

  pcc_pkg::pixel_t red_next, green_next, blue_next;

  // sum*255 + half, then take the integer part, clamp to 0..255
  function automatic pcc_pkg::pixel_t scale(input pcc_pkg::sum_t s);
    logic signed [32:0] t;
    pcc_pkg::pixel_t o;
    t = (33'(s) <<< pcc_pkg::PIXEL_BITS) - 33'(s) + 33'sd32768;
    priority if (t[32]) begin
      o = '0;
    end else if (|t[31:16+pcc_pkg::PIXEL_BITS]) begin
      o = '1;
    end else begin
      o = t[16 +: pcc_pkg::PIXEL_BITS];
    end
    return o;
  endfunction

  always_comb begin
    red_next   = scale(sum_r);
    green_next = scale(sum_g);
    blue_next  = scale(sum_b);
  end

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

`default_nettype wire
